// ===== rtl/core/bbc_pkg.sv =====
`timescale 1ns / 1ps
// bbc_pkg: shared types and constants for the bracket balance checker
package bbc_pkg;

    // token kinds as delivered by the lexer
    localparam logic [4:0] TK_OTHER      = 5'd0;
    localparam logic [4:0] TK_SPACE      = 5'd1;
    localparam logic [4:0] TK_LINE_CMT   = 5'd2;
    localparam logic [4:0] TK_OPEN_CMT   = 5'd3;
    localparam logic [4:0] TK_CLOSE_CMT  = 5'd4;
    localparam logic [4:0] TK_LPAREN     = 5'd5;
    localparam logic [4:0] TK_RPAREN     = 5'd6;
    localparam logic [4:0] TK_LSQUARE    = 5'd7;
    localparam logic [4:0] TK_RSQUARE    = 5'd8;
    localparam logic [4:0] TK_LBRACE     = 5'd9;
    localparam logic [4:0] TK_RBRACE     = 5'd10;
    localparam logic [4:0] TK_SEMI       = 5'd11;
    localparam logic [4:0] TK_HASH_IF    = 5'd12;
    localparam logic [4:0] TK_HASH_ENDIF = 5'd13;
    localparam logic [4:0] TK_HASH_OTHER = 5'd14;
    localparam logic [4:0] TK_BACKSLASH  = 5'd15;
    localparam logic [4:0] TK_COMMA      = 5'd16;
    localparam logic [4:0] TK_EOL        = 5'd17;
    localparam logic [4:0] TK_TEMPLATE   = 5'd18;

    // request types
    localparam logic REQ_TOKEN = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // stack entry codes, empty marks an empty stack
    typedef logic [2:0] entry_t;
    localparam entry_t ENT_PAREN    = 3'd0;
    localparam entry_t ENT_SQUARE   = 3'd1;
    localparam entry_t ENT_BRACE    = 3'd2;
    localparam entry_t ENT_COMMENT  = 3'd3;
    localparam entry_t ENT_HASH     = 3'd4;
    localparam entry_t ENT_TEMPLATE = 3'd5;
    localparam entry_t ENT_EMPTY    = 3'd7;

    // line status codes
    localparam logic [1:0] ST_COMPLETE   = 2'd0;
    localparam logic [1:0] ST_INCOMPLETE = 2'd1;
    localparam logic [1:0] ST_MISMATCH   = 2'd2;
    localparam logic [1:0] ST_OVERFLOW   = 2'd3;

    localparam int DEPTH_FIELD_MAX = 63;

    // classified operations
    typedef enum logic [3:0] {
        OP_CLEAR,
        OP_EOL,
        OP_SPACE,
        OP_LINE_CMT,
        OP_PUSH,
        OP_CLOSE,
        OP_SEMI,
        OP_TEMPLATE,
        OP_CONT,
        OP_OTHER
    } op_t;

    // one classified item in the queue
    typedef struct packed {
        op_t    op;
        entry_t code;      // entry pushed or expected by a closer
        logic   is_brace;  // closing brace, may also drop a lone template
    } item_t;

endpackage

// ===== rtl/core/bbc_front.sv =====
`timescale 1ns / 1ps
// bbc_front: accepts token transactions and classifies them into queue items
module bbc_front (
    input  logic          tok_valid,
    output logic          tok_ready,
    input  logic          req_type,
    input  logic [4:0]    token_kind,
    output logic          q_wr_valid,
    input  logic          q_wr_ready,
    output bbc_pkg::item_t q_wr_item
);
    import bbc_pkg::*;

    always_comb
    begin
        q_wr_item          = '0;
        q_wr_item.op       = OP_OTHER;
        q_wr_item.code     = ENT_EMPTY;
        q_wr_item.is_brace = 1'b0;
        if (req_type == REQ_CLEAR)
        begin
            q_wr_item.op = OP_CLEAR;
        end
        else
        begin
            case (token_kind)
                TK_SPACE:     q_wr_item.op = OP_SPACE;
                TK_LINE_CMT:  q_wr_item.op = OP_LINE_CMT;
                TK_EOL:       q_wr_item.op = OP_EOL;
                TK_SEMI:      q_wr_item.op = OP_SEMI;
                TK_TEMPLATE:  q_wr_item.op = OP_TEMPLATE;
                TK_OPEN_CMT:
                begin
                    q_wr_item.op   = OP_PUSH;
                    q_wr_item.code = ENT_COMMENT;
                end
                TK_LPAREN:
                begin
                    q_wr_item.op   = OP_PUSH;
                    q_wr_item.code = ENT_PAREN;
                end
                TK_LSQUARE:
                begin
                    q_wr_item.op   = OP_PUSH;
                    q_wr_item.code = ENT_SQUARE;
                end
                TK_LBRACE:
                begin
                    q_wr_item.op   = OP_PUSH;
                    q_wr_item.code = ENT_BRACE;
                end
                TK_HASH_IF:
                begin
                    q_wr_item.op   = OP_PUSH;
                    q_wr_item.code = ENT_HASH;
                end
                TK_CLOSE_CMT:
                begin
                    q_wr_item.op   = OP_CLOSE;
                    q_wr_item.code = ENT_COMMENT;
                end
                TK_RPAREN:
                begin
                    q_wr_item.op   = OP_CLOSE;
                    q_wr_item.code = ENT_PAREN;
                end
                TK_RSQUARE:
                begin
                    q_wr_item.op   = OP_CLOSE;
                    q_wr_item.code = ENT_SQUARE;
                end
                TK_RBRACE:
                begin
                    q_wr_item.op       = OP_CLOSE;
                    q_wr_item.code     = ENT_BRACE;
                    q_wr_item.is_brace = 1'b1;
                end
                TK_HASH_ENDIF:
                begin
                    q_wr_item.op   = OP_CLOSE;
                    q_wr_item.code = ENT_HASH;
                end
                TK_BACKSLASH, TK_COMMA: q_wr_item.op = OP_CONT;
                default:      q_wr_item.op = OP_OTHER;  // other, other #, unknown kinds
            endcase
        end
    end

    assign q_wr_valid = tok_valid;
    assign tok_ready  = q_wr_ready;

endmodule

// ===== rtl/core/bbc_fifo.sv =====
`timescale 1ns / 1ps
// bbc_fifo: four-entry queue of classified items between front and back
module bbc_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  bbc_pkg::item_t wr_item,
    output logic           rd_valid,
    input  logic           rd_ready,
    output bbc_pkg::item_t rd_item
);
    import bbc_pkg::*;

    localparam int QD = 4;

    item_t      slot_reg [QD];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] fill_reg, fill_next;
    logic       do_wr, do_rd;

    assign wr_ready = (fill_reg != 3'(QD));
    assign rd_valid = (fill_reg != 3'd0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid & wr_ready;
    assign do_rd    = rd_valid & rd_ready;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 3'd1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ===== rtl/core/bbc_back.sv =====
`timescale 1ns / 1ps
// bbc_back: stack engine with stack memory, line flags and result register
module bbc_back #(
    parameter int STACK_DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  bbc_pkg::item_t q_item,
    output logic           res_valid,
    input  logic           res_ready,
    output logic [1:0]     line_status,
    output logic [5:0]     open_depth
);
    import bbc_pkg::*;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int EXT_W  = (CNT_W > 6) ? CNT_W : 6;

    // stack storage
    entry_t              mem [STACK_DEPTH];
    entry_t              mem_rd_reg;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CNT_W-1:0]    cnt_dec;

    // stack control
    logic [CNT_W-1:0] count_reg, count_next;
    entry_t           top_reg, top_next;
    logic             use_mem_reg, use_mem_next;
    logic             bot_tmpl_reg, bot_tmpl_next;

    // line flags
    logic at_start_reg, at_start_next;
    logic skip_reg, skip_next;
    logic mism_reg, mism_next;
    logic ovf_reg, ovf_next;
    logic cont_reg, cont_next;

    // result register
    logic       res_valid_reg, res_valid_next;
    logic [1:0] status_reg;
    logic [5:0] depth_reg;
    logic [1:0] status_calc;
    logic [5:0] depth_calc;
    logic [EXT_W-1:0] cnt_ext;

    entry_t top_code;
    logic   full;
    logic   take;
    logic   out_free;

    assign full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign top_code = (count_reg == '0) ? ENT_EMPTY : (use_mem_reg ? mem_rd_reg : top_reg);
    assign out_free = !res_valid_reg || res_ready;
    assign take     = q_valid && ((q_item.op != OP_EOL) || out_free);
    assign q_ready  = take;

    assign wr_addr = count_reg[ADDR_W-1:0];
    assign cnt_dec = count_next - CNT_W'(1);
    assign rd_addr = cnt_dec[ADDR_W-1:0];

    // line summary for end of line
    assign cnt_ext    = EXT_W'(count_reg);
    assign depth_calc = (cnt_ext > EXT_W'(DEPTH_FIELD_MAX)) ? 6'(DEPTH_FIELD_MAX)
                                                            : cnt_ext[5:0];
    always_comb
    begin
        if (ovf_reg)
            status_calc = ST_OVERFLOW;
        else if (cont_reg)
            status_calc = ST_INCOMPLETE;
        else if (mism_reg)
            status_calc = ST_MISMATCH;
        else if (count_reg != '0)
            status_calc = ST_INCOMPLETE;
        else
            status_calc = ST_COMPLETE;
    end

    always_comb
    begin
        count_next     = count_reg;
        top_next       = top_reg;
        use_mem_next   = use_mem_reg;
        bot_tmpl_next  = bot_tmpl_reg;
        at_start_next  = at_start_reg;
        skip_next      = skip_reg;
        mism_next      = mism_reg;
        ovf_next       = ovf_reg;
        cont_next      = cont_reg;
        wr_en          = 1'b0;
        res_valid_next = res_valid_reg && !res_ready;

        if (take)
        begin
            case (q_item.op)
                OP_CLEAR:
                begin
                    count_next    = '0;
                    at_start_next = 1'b1;
                    skip_next     = 1'b0;
                    mism_next     = 1'b0;
                    ovf_next      = 1'b0;
                    cont_next     = 1'b0;
                end
                OP_EOL:
                begin
                    res_valid_next = 1'b1;
                    at_start_next  = 1'b1;
                    skip_next      = 1'b0;
                    mism_next      = 1'b0;
                    ovf_next       = 1'b0;
                    cont_next      = 1'b0;
                end
                OP_SPACE:
                begin
                end
                default:
                begin
                    if (!skip_reg)
                    begin
                        at_start_next = 1'b0;
                        cont_next     = (q_item.op == OP_CONT);
                        // inside a block comment only its closer counts
                        if (top_code == ENT_COMMENT &&
                            !(q_item.op == OP_CLOSE && q_item.code == ENT_COMMENT))
                        begin
                        end
                        else
                        begin
                            case (q_item.op)
                                OP_LINE_CMT:
                                begin
                                    skip_next = 1'b1;
                                end
                                OP_PUSH:
                                begin
                                    if (full)
                                    begin
                                        ovf_next  = 1'b1;
                                        skip_next = 1'b1;
                                    end
                                    else
                                    begin
                                        wr_en        = 1'b1;
                                        top_next     = q_item.code;
                                        use_mem_next = 1'b0;
                                        count_next   = count_reg + CNT_W'(1);
                                        if (count_reg == '0)
                                            bot_tmpl_next = 1'b0;
                                    end
                                end
                                OP_CLOSE:
                                begin
                                    if (top_code != q_item.code)
                                    begin
                                        mism_next = 1'b1;
                                        skip_next = 1'b1;
                                    end
                                    else if (q_item.is_brace && bot_tmpl_reg &&
                                             count_reg == CNT_W'(2))
                                    begin
                                        // brace pop leaves a lone template, drop it too
                                        count_next = '0;
                                    end
                                    else
                                    begin
                                        count_next   = count_reg - CNT_W'(1);
                                        use_mem_next = 1'b1;
                                    end
                                end
                                OP_SEMI:
                                begin
                                    if (bot_tmpl_reg && count_reg == CNT_W'(1))
                                        count_next = '0;
                                end
                                OP_TEMPLATE:
                                begin
                                    if (at_start_reg && count_reg == '0)
                                    begin
                                        wr_en         = 1'b1;
                                        top_next      = ENT_TEMPLATE;
                                        use_mem_next  = 1'b0;
                                        count_next    = CNT_W'(1);
                                        bot_tmpl_next = 1'b1;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
            endcase
        end
    end

    // stack memory, registered read of the entry that becomes the top
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= top_next;
        end
        mem_rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (take && q_item.op == OP_EOL)
        begin
            status_reg <= status_calc;
            depth_reg  <= depth_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            use_mem_reg   <= 1'b0;
            bot_tmpl_reg  <= 1'b0;
            at_start_reg  <= 1'b1;
            skip_reg      <= 1'b0;
            mism_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            cont_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            use_mem_reg   <= use_mem_next;
            bot_tmpl_reg  <= bot_tmpl_next;
            at_start_reg  <= at_start_next;
            skip_reg      <= skip_next;
            mism_reg      <= mism_next;
            ovf_reg       <= ovf_next;
            cont_reg      <= cont_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign line_status = status_reg;
    assign open_depth  = depth_reg;

endmodule

// ===== rtl/core/bracket_balance_checker_core.sv =====
`timescale 1ns / 1ps
// bracket_balance_checker_core: top level of the bracket balance checker
//
// takes one lexed token (or a clear request) per transaction and tracks open
// parentheses, brackets, braces, block comments, #if directives and a leading
// template marker on a stack of STACK_DEPTH entries; each end-of-line token
// gives one result transaction with the line status and the open depth
// (saturated at 63), every other token and a clear give none. tokens go
// through at one per cycle unless stalled: the front classifies each token
// into a four-entry queue and the back stage retires one queued token per
// clock, reading only the stack top, which comes from a top register or
// from the registered read port of the stack memory. a result that is not
// taken stalls only the next end-of-line token; tokens behind it keep
// filling the queue. results pass a queue slot and the result register.
module bracket_balance_checker_core #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    // token channel
    input  logic       tok_valid,
    output logic       tok_ready,
    input  logic       req_type,
    input  logic [4:0] token_kind,
    // result channel
    output logic       res_valid,
    input  logic       res_ready,
    output logic [1:0] line_status,
    output logic [5:0] open_depth
);
    import bbc_pkg::*;

    // classified transaction from front to queue
    logic  q_wr_valid;
    logic  q_wr_ready;
    item_t q_wr_item;

    // queue to back stage
    logic  q_rd_valid;
    logic  q_rd_ready;
    item_t q_rd_item;

    // front: accept and classify
    bbc_front u_front (
        .tok_valid  (tok_valid),
        .tok_ready  (tok_ready),
        .req_type   (req_type),
        .token_kind (token_kind),
        .q_wr_valid (q_wr_valid),
        .q_wr_ready (q_wr_ready),
        .q_wr_item  (q_wr_item)
    );

    // decoupling queue
    bbc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_item  (q_wr_item),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_item  (q_rd_item)
    );

    // back: stack engine and result register
    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_rd_valid),
        .q_ready     (q_rd_ready),
        .q_item      (q_rd_item),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .line_status (line_status),
        .open_depth  (open_depth)
    );

endmodule
